>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, reset included.
`define RTMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the block is out of reset.
`define RTMR_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/rtmr_pkg.sv
// Shared types, constants and helpers of the reload timer.
package rtmr_pkg;

  localparam int unsigned CHANNELS_DEF   = 3;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IRQ_W   = 3;
  localparam int unsigned CTRL_W  = 16;
  localparam int unsigned PHASE_W = 10;
  localparam int unsigned PSC_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [CTRL_W-1:0]  ctrl_t;

  localparam ctrl_t FLAG_UNDERFLOW = 16'h0100;
  localparam ctrl_t FLAG_IRQ_EN    = 16'h0020;

  localparam logic [IDX_W-1:0] REG_START = 4'd0;

  // Prescaler code to log2 of the divide ratio.
  localparam int PSC_SHIFT [8] = '{2, 4, 6, 8, 10, 0, 0, 0};

  // Per-channel command decoded from one beat.
  typedef struct packed {
    logic tick;
    logic ctrl_wr;
    logic cnt_wr;
    logic rld_wr;
    logic start_rise;
    logic stop;
    logic run;
  } chan_cmd_t;

  function automatic phase_t last_phase(input logic [PSC_W-1:0] code);
    return phase_t'((1 << PSC_SHIFT[code]) - 1);
  endfunction

endpackage

>>> rtl/rtmr_in_if.sv
// Request channel: tick, register write or register read.
interface rtmr_in_if
  import rtmr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, kind, reg_index, write_data, input ready);
  modport sink   (input valid, kind, reg_index, write_data, output ready);
endinterface

>>> rtl/rtmr_out_if.sv
// Result channel: read data and interrupt request bits.
interface rtmr_out_if
  import rtmr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  irq_pending;

  modport source (output valid, read_data, irq_pending, input ready);
  modport sink   (input valid, read_data, irq_pending, output ready);
endinterface

>>> rtl/rtmr_channel.sv
// One timer channel: control, count, reload, prescale phase and irq bit.
module rtmr_channel
  import rtmr_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chan_cmd_t             cmd,
  input  logic [DATA_W-1:0]     wdata,
  output ctrl_t                 ctrl_q,
  output logic [COUNT_BITS-1:0] cnt_q,
  output logic [COUNT_BITS-1:0] rld_q,
  output logic                  irq_nxt
);

  ctrl_t                 ctrl_r, ctrl_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] rld_r, rld_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  irq_r;
  logic                  uflow;
  logic [COUNT_BITS-1:0] wcount;
  ctrl_t                 wctrl;

  assign wcount = wdata[COUNT_BITS-1:0];
  assign wctrl  = wdata[CTRL_W-1:0];

  always_comb begin
    ctrl_nxt  = ctrl_r;
    cnt_nxt   = cnt_r;
    rld_nxt   = rld_r;
    phase_nxt = phase_r;
    irq_nxt   = irq_r;
    uflow     = 1'b0;

    if (cmd.tick && cmd.run) begin
      if (phase_r < last_phase(ctrl_r[PSC_W-1:0])) begin
        phase_nxt = phase_r + phase_t'(1);
      end else begin
        phase_nxt = '0;
        if (cnt_r <= COUNT_BITS'(1)) begin
          uflow = 1'b1;
        end else begin
          cnt_nxt = cnt_r - COUNT_BITS'(1);
        end
      end
    end

    if (cmd.ctrl_wr) begin
      ctrl_nxt = wctrl;
      // irq survives only if the written value keeps both enable and flag
      if ((wctrl & (FLAG_IRQ_EN | FLAG_UNDERFLOW)) != (FLAG_IRQ_EN | FLAG_UNDERFLOW)) begin
        irq_nxt = 1'b0;
      end
      if (cmd.run) begin
        phase_nxt = '0;
        if (cnt_r == '0) uflow = 1'b1;
      end
    end

    if (cmd.cnt_wr) begin
      cnt_nxt = wcount;
      if (cmd.run) begin
        phase_nxt = '0;
        if (wcount == '0) uflow = 1'b1;
      end
    end

    if (cmd.rld_wr) begin
      rld_nxt = wcount;
    end

    if (cmd.start_rise) begin
      phase_nxt = '0;
      if (cnt_r == '0) uflow = 1'b1;
    end

    if (cmd.stop) begin
      phase_nxt = '0;
    end

    if (uflow) begin
      ctrl_nxt = ctrl_nxt | FLAG_UNDERFLOW;
      if ((ctrl_nxt & FLAG_IRQ_EN) != '0) irq_nxt = 1'b1;
      cnt_nxt = rld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      cnt_r   <= '1;
      rld_r   <= '1;
      phase_r <= '0;
      irq_r   <= 1'b0;
    end else begin
      ctrl_r  <= ctrl_nxt;
      cnt_r   <= cnt_nxt;
      rld_r   <= rld_nxt;
      phase_r <= phase_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign ctrl_q = ctrl_r;
  assign cnt_q  = cnt_r;
  assign rld_q  = rld_r;

endmodule

>>> rtl/three_channel_reload_timer_core.sv
// Path: an accepted beat passes the input register, then the result register.
// Throughput: one beat per clock while the result side does not stall; the input and result
// registers part the two sides, and the whole timer update for a beat sits between them.
// Reset (rst_n low, synchronous): channels stopped, control and phase zero, count and
// reload all ones, irq bits clear, both pipeline registers empty.
// Top level of the three-channel reload timer.
module three_channel_reload_timer_core
  import rtmr_pkg::*;
#(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rtmr_in_if.sink    in_ch,
  rtmr_out_if.source out_ch
);

  localparam int unsigned XIDX_W = 8;   // room for every register index up to 3*CHANNELS

  // ---------------------------------------------------------------------------
  // Input register: holds one beat until the timer state can take it.
  // ---------------------------------------------------------------------------
  logic              in_vld_r;
  kind_t             kind_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] wdata_r;
  logic              adv;
  logic              in_rdy;

  logic              out_vld_r;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic [IRQ_W-1:0]  irq_out_r, irq_out_nxt;

  // The held beat retires when the result register is free or being emptied.
  assign adv    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy = !in_vld_r || adv;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      kind_r  <= kind_t'(in_ch.kind);
      idx_r   <= in_ch.reg_index;
      wdata_r <= in_ch.write_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat decode. State changes below are gated by adv so state moves once per beat.
  // ---------------------------------------------------------------------------
  logic [XIDX_W-1:0]   idx_x;
  logic                is_tick, is_wr, is_rd;
  logic                start_wr;
  logic [CHANNELS-1:0] start_r, start_nxt;

  assign idx_x    = XIDX_W'(idx_r);
  assign is_tick  = adv && (kind_r == KIND_TICK);
  assign is_wr    = adv && (kind_r == KIND_WRITE);
  assign is_rd    = kind_r == KIND_READ;
  assign start_wr = is_wr && (idx_r == REG_START);
  assign start_nxt = start_wr ? wdata_r[CHANNELS-1:0] : start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else begin
      start_r <= start_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Channels. Register map: start, then all control, all count, all reload registers.
  // ---------------------------------------------------------------------------
  ctrl_t                 ctrl_q  [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_q   [CHANNELS];
  logic [COUNT_BITS-1:0] rld_q   [CHANNELS];
  logic [CHANNELS-1:0]   irq_nxt_v;
  logic [CHANNELS-1:0]   hit_ctrl, hit_cnt, hit_rld;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    localparam logic [XIDX_W-1:0] IDX_CTRL = XIDX_W'(1 + c);
    localparam logic [XIDX_W-1:0] IDX_CNT  = XIDX_W'(1 + CHANNELS + c);
    localparam logic [XIDX_W-1:0] IDX_RLD  = XIDX_W'(1 + 2 * CHANNELS + c);

    chan_cmd_t cmd;

    assign hit_ctrl[c] = idx_x == IDX_CTRL;
    assign hit_cnt[c]  = idx_x == IDX_CNT;
    assign hit_rld[c]  = idx_x == IDX_RLD;

    assign cmd.tick       = is_tick;
    assign cmd.ctrl_wr    = is_wr && hit_ctrl[c];
    assign cmd.cnt_wr     = is_wr && hit_cnt[c];
    assign cmd.rld_wr     = is_wr && hit_rld[c];
    // start edge restarts the phase; clearing the bit parks it at zero
    assign cmd.start_rise = start_wr && start_nxt[c] && !start_r[c];
    assign cmd.stop       = start_wr && !start_nxt[c];
    assign cmd.run        = start_r[c];

    rtmr_channel #(
      .COUNT_BITS (COUNT_BITS)
    ) u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .wdata   (wdata_r),
      .ctrl_q  (ctrl_q[c]),
      .cnt_q   (cnt_q[c]),
      .rld_q   (rld_q[c]),
      .irq_nxt (irq_nxt_v[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Result: read mux on pre-beat state, irq bits after the beat.
  // ---------------------------------------------------------------------------
  logic [IRQ_W+CHANNELS-1:0] irq_wide;

  always_comb begin
    rdata_nxt = '0;
    if (is_rd) begin
      if (idx_r == REG_START) rdata_nxt = DATA_W'(start_r);
      for (int c = 0; c < CHANNELS; c++) begin
        if (hit_ctrl[c]) rdata_nxt = DATA_W'(ctrl_q[c]);
        if (hit_cnt[c])  rdata_nxt = DATA_W'(cnt_q[c]);
        if (hit_rld[c])  rdata_nxt = DATA_W'(rld_q[c]);
      end
    end
  end

  // channels beyond the port width are dropped, missing ones read as zero
  assign irq_wide    = {{IRQ_W{1'b0}}, irq_nxt_v};
  assign irq_out_nxt = irq_wide[IRQ_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r   <= rdata_nxt;
      irq_out_r <= irq_out_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.read_data   = rdata_r;
  assign out_ch.irq_pending = irq_out_r;

endmodule

>>> rtl/rtmr_checker.sv
// Port-level checker for the reload timer, bound to the top level.
`include "assert_macros.svh"

module rtmr_checker
  import rtmr_pkg::*;
  (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_data,
  input logic [IRQ_W-1:0]  out_irq_pending
);

  // Nothing comes out right after reset.
  `RTMR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result beat holds its payload.
  `RTMR_ASSERT_RUN(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_irq_pending),
    "stalled result changed")

  // Once an accepted beat has passed the input register, the result register holds a beat;
  // under a stall that may still be an older one.
  `RTMR_ASSERT_RUN(a_latency, in_valid && in_ready |=> ##1 out_valid,
    "accepted beat produced no result")

  // With the result register empty the input side never stalls.
  `RTMR_ASSERT_RUN(a_no_idle_stall, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind three_channel_reload_timer_core rtmr_checker u_rtmr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_read_data   (out_ch.read_data),
  .out_irq_pending (out_ch.irq_pending)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-channel reload timer: directed table, then random beats.
module testbench;
  import rtmr_pkg::*;

  // Register map as the timer decodes it: start bits, then three control, three count
  // and three reload registers; anything above the last reload register is unmapped.
  localparam logic [IDX_W-1:0] REG_CTL0  = 4'd1;
  localparam logic [IDX_W-1:0] REG_CNT0  = 4'd4;
  localparam logic [IDX_W-1:0] REG_RLD0  = 4'd7;
  localparam logic [IDX_W-1:0] REG_LAST  = 4'd9;
  localparam logic [IDX_W-1:0] REG_NONE  = 4'd10;
  localparam logic [IDX_W-1:0] REG_TOP   = 4'd15;

  localparam int NCH = 3;
  // log2 of the divide ratio for each prescaler code
  localparam int DIV_LOG2 [8] = '{2, 4, 6, 8, 10, 0, 0, 0};

  localparam bit FIXED   = 1'b1;  // row carries its own expected beat
  localparam bit MODELED = 1'b0;  // row is checked against the predictor

  localparam int N_DIR      = 25;
  localparam int N_RAND     = 400;  // per idle phase
  localparam int LONG_HOLD  = 300;  // receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 8;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [IRQ_W-1:0]  irq;
  } timer_result_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    bit                fixed;
    timer_result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  rtmr_in_if  in_ch ();
  rtmr_out_if out_ch ();

  three_channel_reload_timer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Timer predictor: its own copy of every register, stepped once per accepted beat.
  // ---------------------------------------------------------------------------
  logic [NCH-1:0]     tmr_run;
  logic [CTRL_W-1:0]  tmr_ctl [NCH];
  logic [DATA_W-1:0]  tmr_cnt [NCH];
  logic [DATA_W-1:0]  tmr_rld [NCH];
  logic [PHASE_W-1:0] tmr_psc [NCH];
  logic [NCH-1:0]     tmr_irq;

  timer_result_t expected_q [$];
  int            errors = 0;

  int src_idle_pct;
  int snk_idle_pct;
  int holds_wanted = 0;
  int holds_done   = 0;
  int hold_left    = 0;

  // Underflow: latch the flag, raise the request if enabled, reload the count.
  function automatic void chan_underflow(input int c);
    tmr_ctl[c] = tmr_ctl[c] | FLAG_UNDERFLOW;
    if ((tmr_ctl[c] & FLAG_IRQ_EN) != '0) tmr_irq[c] = 1'b1;
    tmr_cnt[c] = tmr_rld[c];
  endfunction

  // Restart zeroes the prescale phase; a zero count underflows right away.
  function automatic void chan_restart(input int c);
    tmr_psc[c] = '0;
    if (tmr_cnt[c] == '0) chan_underflow(c);
  endfunction

  function automatic timer_result_t timer_step(input kind_t k, input logic [IDX_W-1:0] idx,
                                               input logic [DATA_W-1:0] d);
    timer_result_t  r;
    logic [NCH-1:0] was_run;
    int             last;
    int             c;
    r.rd = '0;
    case (k)
      KIND_TICK: begin
        for (c = 0; c < NCH; c++) begin
          if (tmr_run[c]) begin
            last = (1 << DIV_LOG2[tmr_ctl[c][PSC_W-1:0]]) - 1;
            if (int'(tmr_psc[c]) < last) begin
              tmr_psc[c] = tmr_psc[c] + 1'b1;
            end else begin
              tmr_psc[c] = '0;
              if (tmr_cnt[c] <= 1) chan_underflow(c);
              else tmr_cnt[c] = tmr_cnt[c] - 1'b1;
            end
          end
        end
      end
      KIND_WRITE: begin
        if (idx == REG_START) begin
          was_run = tmr_run;
          tmr_run = d[NCH-1:0];
          for (c = 0; c < NCH; c++) begin
            if (tmr_run[c] && !was_run[c]) chan_restart(c);
            else if (!tmr_run[c]) tmr_psc[c] = '0;
          end
        end else if (idx < REG_CNT0) begin
          c = int'(idx - REG_CTL0);
          tmr_ctl[c] = d[CTRL_W-1:0];
          // the clear test looks at the written value, before any restart underflow
          if ((tmr_ctl[c] & (FLAG_UNDERFLOW | FLAG_IRQ_EN)) != (FLAG_UNDERFLOW | FLAG_IRQ_EN))
            tmr_irq[c] = 1'b0;
          if (tmr_run[c]) chan_restart(c);
        end else if (idx < REG_RLD0) begin
          c = int'(idx - REG_CNT0);
          tmr_cnt[c] = d;
          if (tmr_run[c]) chan_restart(c);
        end else if (idx <= REG_LAST) begin
          tmr_rld[int'(idx - REG_RLD0)] = d;
        end
      end
      KIND_READ: begin
        if (idx == REG_START) r.rd = DATA_W'(tmr_run);
        else if (idx < REG_CNT0) r.rd = DATA_W'(tmr_ctl[int'(idx - REG_CTL0)]);
        else if (idx < REG_RLD0) r.rd = tmr_cnt[int'(idx - REG_CNT0)];
        else if (idx <= REG_LAST) r.rd = tmr_rld[int'(idx - REG_RLD0)];
      end
      KIND_NOP: ;
      default: ;
    endcase
    r.irq = IRQ_W'(tmr_irq);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. valid moves only at rising edges; acceptance is judged on the
  // pre-edge values, so the predictor sees exactly the beats the block took.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input kind_t k, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] d, input bit fixed,
                           input timer_result_t want);
    timer_result_t modeled;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.reg_index  <= idx;
    in_ch.write_data <= d;
    do @(posedge clk); while (!in_ch.ready);
    // the predictor always steps; a fixed row just supplies the beat to compare against
    modeled = timer_step(k, idx, d);
    expected_q.push_back(fixed ? want : modeled);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request so the
  // pipeline fills and pushes back on the request channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holds_done < holds_wanted) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Every result beat is matched against the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, read_data %h irq_pending %b",
                 $time, out_ch.read_data, out_ch.irq_pending);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.read_data !== want.rd) begin
          $display("%0t: read_data mismatch, expected %h actual %h",
                   $time, want.rd, out_ch.read_data);
          errors++;
        end
        if (out_ch.irq_pending !== want.irq) begin
          $display("%0t: irq_pending mismatch, expected %b actual %b",
                   $time, want.irq, out_ch.irq_pending);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [N_DIR];

  initial begin : stimulus
    int               ph;
    int               n;
    int               pick;
    kind_t            k;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] d;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_TICK;
    in_ch.reg_index  <= REG_START;
    in_ch.write_data <= '0;
    src_idle_pct = 20;
    snk_idle_pct = 59;

    // predictor reset state
    tmr_run = '0;
    tmr_irq = '0;
    for (n = 0; n < NCH; n++) begin
      tmr_ctl[n] = '0;
      tmr_cnt[n] = '1;
      tmr_rld[n] = '1;
      tmr_psc[n] = '0;
    end

    // Directed rows. Expected beats are typed in only where they are plain from the
    // reset state: reset values, unmapped indices, the no-op kind, upper data bits
    // dropped on a control write. Everything after the start write is modeled.
    dir_rows = '{
      '{KIND_READ,  REG_START,        32'h0,         FIXED,   {32'h0,         3'b000}},
      '{KIND_READ,  REG_CTL0,         32'h0,         FIXED,   {32'h0,         3'b000}},
      '{KIND_READ,  REG_CNT0 + 4'd2,  32'h0,         FIXED,   {32'hFFFF_FFFF, 3'b000}},
      '{KIND_READ,  REG_RLD0 + 4'd1,  32'h0,         FIXED,   {32'hFFFF_FFFF, 3'b000}},
      '{KIND_READ,  REG_TOP,          32'hFFFF_FFFF, FIXED,   {32'h0,         3'b000}},
      '{KIND_NOP,   REG_CNT0,         32'hFFFF_FFFF, FIXED,   {32'h0,         3'b000}},
      '{KIND_TICK,  REG_TOP,          32'hFFFF_FFFF, FIXED,   {32'h0,         3'b000}},
      // unmapped write is dropped
      '{KIND_WRITE, 4'd12,            32'hFFFF_FFFF, FIXED,   {32'h0,         3'b000}},
      '{KIND_READ,  REG_NONE,         32'h0,         FIXED,   {32'h0,         3'b000}},
      // zero reload on ch0, then per-tick prescale with enable and flag preset
      '{KIND_WRITE, REG_RLD0,         32'h0,         FIXED,   {32'h0,         3'b000}},
      '{KIND_WRITE, REG_CTL0,         32'hFFFF_0125, FIXED,   {32'h0,         3'b000}},
      '{KIND_READ,  REG_CTL0,         32'h0,         FIXED,   {32'h0000_0125, 3'b000}},
      '{KIND_WRITE, REG_CNT0,         32'h0,         FIXED,   {32'h0,         3'b000}},
      // start all: ch0 has count zero and underflows at once
      '{KIND_WRITE, REG_START,        32'hFFFF_FFFF, MODELED, {32'h0,         3'b000}},
      '{KIND_TICK,  REG_START,        32'h0,         MODELED, {32'h0,         3'b000}},
      '{KIND_TICK,  REG_START,        32'h0,         MODELED, {32'h0,         3'b000}},
      // flag without enable drops ch0's request
      '{KIND_WRITE, REG_CTL0,         32'h0000_0100, MODELED, {32'h0,         3'b000}},
      '{KIND_WRITE, REG_CTL0 + 4'd1,  32'h0000_0024, MODELED, {32'h0,         3'b000}},
      '{KIND_WRITE, REG_CNT0 + 4'd1,  32'h0000_0001, MODELED, {32'h0,         3'b000}},
      '{KIND_WRITE, REG_CTL0 + 4'd2,  32'h0000_0003, MODELED, {32'h0,         3'b000}},
      // count write of zero on a running channel
      '{KIND_WRITE, REG_CNT0 + 4'd2,  32'h0,         MODELED, {32'h0,         3'b000}},
      '{KIND_WRITE, REG_RLD0 + 4'd1,  32'h0000_0002, MODELED, {32'h0,         3'b000}},
      '{KIND_READ,  REG_CNT0,         32'h0,         MODELED, {32'h0,         3'b000}},
      '{KIND_WRITE, REG_START,        32'h0,         MODELED, {32'h0,         3'b000}},
      '{KIND_WRITE, REG_START,        32'h0000_0002, MODELED, {32'h0,         3'b000}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIR; n++)
      send_beat(dir_rows[n].kind, dir_rows[n].idx, dir_rows[n].data,
                dir_rows[n].fixed, dir_rows[n].want);

    // Random beats in three idle phases: sender-light, receiver-light, none.
    // Ticks dominate so channels really run down; counts and reloads are mostly
    // small and prescalers mostly fast so underflows happen often.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 20; snk_idle_pct = 59; end
        1: begin src_idle_pct = 59; snk_idle_pct = 20; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (n = 0; n < N_RAND; n++) begin
        if (ph == 0 && n == 40) holds_wanted = 1;
        pick = $urandom_range(0, 99);
        d    = $urandom;
        idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(10, 15))
                                           : IDX_W'($urandom_range(0, 9));
        if (pick < 55) k = KIND_TICK;
        else if (pick < 80) k = KIND_WRITE;
        else if (pick < 97) k = KIND_READ;
        else k = KIND_NOP;
        if (k == KIND_WRITE) begin
          if (idx == REG_START) begin
            if ($urandom_range(0, 3) != 0) d = DATA_W'($urandom_range(0, 7));
          end else if (idx < REG_CNT0) begin
            // upper bits stay random to exercise the truncation
            d[PSC_W-1:0] = ($urandom_range(0, 3) != 0) ? PSC_W'($urandom_range(5, 7))
                                                        : PSC_W'($urandom_range(0, 4));
          end else if (idx <= REG_LAST) begin
            if ($urandom_range(0, 7) != 0) d = DATA_W'($urandom_range(0, 12));
          end
        end
        send_beat(k, idx, d, MODELED, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1200 beats, heavy idling,
  // one long receiver hold-off).
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
